// ----- hw/rtl/greedy_independent_set_engine_top_assert.svh -----
// Assertion macros shared by the greedy independent set engine RTL.
// Depends on nothing; included by the controller and datapath modules.
`ifndef GREEDY_INDEPENDENT_SET_ENGINE_TOP_ASSERT_SVH
`define GREEDY_INDEPENDENT_SET_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GISE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GISE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gise_pkg.sv -----
// Package for the greedy independent set engine: sizes, opcodes, word types,
// controller state and the command/status structs. Depends on nothing.
package gise_pkg;

    localparam int MAX_VERTICES  = 1024;
    localparam int WORDS_PER_ROW = 16;
    localparam int WORD_BITS     = 64;
    localparam int BIT_IDX_W     = 6;
    localparam int VERTEX_W      = 10;
    localparam int WIDX_W        = 4;
    localparam int COUNT_W       = 11;
    localparam int ADJ_ADDR_W    = VERTEX_W + WIDX_W;
    localparam int ADJ_DEPTH     = 1 << ADJ_ADDR_W;
    localparam int EFF_LIMIT     = (MAX_VERTICES < WORDS_PER_ROW * WORD_BITS) ?
                                   MAX_VERTICES : WORDS_PER_ROW * WORD_BITS;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] VCOUNT_RESET = COUNT_W'(1024);

    typedef enum logic [1:0] {
        OP_LOAD_ADJ  = 2'd0,
        OP_LOAD_CAND = 2'd1,
        OP_OFFER     = 2'd2,
        OP_NOP       = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [VERTEX_W-1:0]  vertex;
        logic [WIDX_W-1:0]    word_index;
        logic [WORD_BITS-1:0] data_word;
    } in_word_t;

    typedef struct packed {
        logic                selected;
        logic [COUNT_W-1:0]  set_size;
        logic [VERTEX_W-1:0] echo_vertex;
    } out_word_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic sweep;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic eligible;
        logic sweep_last;
        logic out_free;
    } stat_t;

endpackage

// ----- hw/rtl/gise_ctrl.sv -----
// Controller state machine of the greedy independent set engine.
// Depends on gise_pkg and the shared assertion header.
`include "greedy_independent_set_engine_top_assert.svh"

module gise_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gise_pkg::stat_t stat,
    output gise_pkg::cmd_t  cmd
);
    import gise_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = stat.eligible ? S_SWEEP : S_DONE;
            end
            S_SWEEP: begin
                if (stat.sweep_last) state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
            end
            S_DONE: begin
                cmd.finish = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `GISE_ASSERT_NEXT(a_sweep_ends, aclk, aresetn,
        state_reg == S_SWEEP && stat.sweep_last, state_reg == S_DONE,
        "sweep did not end after last word")
    `GISE_ASSERT_NEXT(a_accept_exec, aclk, aresetn,
        cmd.accept, state_reg == S_EXEC,
        "accepted word not executed next cycle")
    `GISE_ASSERT_NEXT(a_exec_leaves, aclk, aresetn,
        state_reg == S_EXEC, state_reg == S_SWEEP || state_reg == S_DONE,
        "execute state held for more than one cycle")

endmodule

// ----- hw/rtl/gise_datapath.sv -----
// Datapath of the greedy independent set engine: adjacency memory, candidate
// mask, set counter and result register. Depends on gise_pkg and the assertion header.
`include "greedy_independent_set_engine_top_assert.svh"

module gise_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  gise_pkg::cmd_t      cmd,
    output gise_pkg::stat_t     stat,
    input  gise_pkg::in_word_t  s_data,
    input  logic                cfg_valid,
    input  logic [gise_pkg::COUNT_W-1:0] cfg_data,
    output gise_pkg::out_word_t m_data,
    output logic                m_valid,
    input  logic                m_ready
);
    import gise_pkg::*;

    logic [WORD_BITS-1:0] adj_mem [ADJ_DEPTH];
    logic [WORD_BITS-1:0] cand_mem [WORDS_PER_ROW];
    logic [WORDS_PER_ROW-1:0] cand_vld_reg;

    in_word_t             in_reg;
    logic [COUNT_W-1:0]   vcount_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [WIDX_W-1:0]    k_reg;
    logic                 sel_reg;
    logic [WORD_BITS-1:0] cand_rd_reg;
    logic [WORD_BITS-1:0] adj_rd_reg;
    out_word_t            m_data_reg;
    logic                 m_valid_reg;

    logic [WIDX_W-1:0]     k_plus;
    logic [WIDX_W-1:0]     cand_raddr;
    logic [WIDX_W-1:0]     adj_widx;
    logic [WIDX_W-1:0]     cand_waddr;
    logic [WORD_BITS-1:0]  cand_wdata;
    logic                  cand_we;
    logic                  adj_we;
    logic [WIDX_W-1:0]     own_word;
    logic [WORD_BITS-1:0]  own_bit;
    logic [COUNT_W-1:0]    limit;
    logic [COUNT_W-1:0]    base;
    logic [COUNT_W-1:0]    base_top;
    logic [COUNT_W-1:0]    span;
    logic [WORD_BITS-1:0]  valid_bits;
    logic                  in_range;

    assign k_plus   = k_reg + WIDX_W'(1);
    assign own_word = in_reg.vertex[VERTEX_W-1 -: WIDX_W];
    assign own_bit  = WORD_BITS'(1) << in_reg.vertex[BIT_IDX_W-1:0];

    // Mask of loadable candidate bits for the addressed word.
    always_comb begin
        limit    = (vcount_reg > COUNT_W'(EFF_LIMIT)) ? COUNT_W'(EFF_LIMIT) : vcount_reg;
        base     = COUNT_W'(in_reg.word_index) << BIT_IDX_W;
        base_top = base + COUNT_W'(WORD_BITS);
        span     = limit - base;
        if (limit >= base_top) begin
            valid_bits = '1;
        end else if (limit <= base) begin
            valid_bits = '0;
        end else begin
            valid_bits = (WORD_BITS'(1) << span[BIT_IDX_W-1:0]) - WORD_BITS'(1);
        end
    end

    assign in_range = (32'(in_reg.vertex) < MAX_VERTICES) &&
                      (32'(own_word) < WORDS_PER_ROW);

    // Read addresses: own word at accept, word zero at execute, next word in sweep.
    always_comb begin
        if (cmd.accept) begin
            cand_raddr = s_data.vertex[VERTEX_W-1 -: WIDX_W];
        end else if (cmd.exec) begin
            cand_raddr = '0;
        end else begin
            cand_raddr = k_plus;
        end
        adj_widx = cmd.exec ? '0 : k_plus;
    end

    always_comb begin
        cand_we    = 1'b0;
        cand_waddr = k_reg;
        cand_wdata = cand_rd_reg & ~adj_rd_reg & ((k_reg == own_word) ? ~own_bit : '1);
        if (cmd.sweep) begin
            cand_we = 1'b1;
        end else if (cmd.exec && in_reg.opcode == OP_LOAD_CAND &&
                     32'(in_reg.word_index) < WORDS_PER_ROW) begin
            cand_we    = 1'b1;
            cand_waddr = in_reg.word_index;
            cand_wdata = in_reg.data_word & valid_bits;
        end
    end

    assign adj_we = cmd.exec && in_reg.opcode == OP_LOAD_ADJ &&
                    32'(in_reg.word_index) < WORDS_PER_ROW &&
                    32'(in_reg.vertex) < MAX_VERTICES;

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[{in_reg.vertex, in_reg.word_index}] <= in_reg.data_word;
        end
        adj_rd_reg <= adj_mem[{in_reg.vertex, adj_widx}];
    end

    always_ff @(posedge aclk) begin
        if (cand_we) begin
            cand_mem[cand_waddr] <= cand_wdata;
        end
        cand_rd_reg <= cand_vld_reg[cand_raddr] ? cand_mem[cand_raddr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_vld_reg <= '0;
        end else if (cand_we) begin
            cand_vld_reg[cand_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_reg <= s_data;
        end
        if (cmd.exec) begin
            sel_reg <= stat.eligible;
            k_reg   <= '0;
        end else if (cmd.sweep) begin
            k_reg <= k_plus;
        end
        if (cmd.finish) begin
            m_data_reg.selected    <= sel_reg;
            m_data_reg.set_size    <= count_reg;
            m_data_reg.echo_vertex <= in_reg.vertex;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg  <= VCOUNT_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                vcount_reg <= cfg_data;
            end
            if (cmd.exec && in_reg.opcode == OP_LOAD_CAND) begin
                count_reg <= '0;
            end else if (cmd.sweep && stat.sweep_last && count_reg != COUNT_MAX) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.eligible   = in_reg.opcode == OP_OFFER && in_range &&
                             cand_rd_reg[in_reg.vertex[BIT_IDX_W-1:0]];
    assign stat.sweep_last = k_reg == WIDX_W'(WORDS_PER_ROW - 1);
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign m_data          = m_data_reg;
    assign m_valid         = m_valid_reg;

    `GISE_ASSERT_NEXT(a_finish_valid, aclk, aresetn, cmd.finish, m_valid_reg, "result not presented after finish")
    `GISE_ASSERT_NEXT(a_cand_clears, aclk, aresetn, cmd.exec && in_reg.opcode == OP_LOAD_CAND, count_reg == '0, "candidate load did not clear set size")
    `GISE_ASSERT_NEXT(a_capture, aclk, aresetn, cmd.accept, in_reg == $past(s_data), "input word not captured")
    `GISE_ASSERT_NOW(a_finish_free, aclk, aresetn, cmd.finish, !m_valid_reg || m_ready, "result overwritten before taken")

endmodule

// ----- hw/rtl/greedy_independent_set_engine_top.sv -----
// Top level of the greedy independent set engine.
// Depends on gise_pkg, gise_ctrl and gise_datapath.
//
// Greedy maximal independent set engine over a bit-matrix adjacency. Each input
// word is one command: opcode 0 writes one 64-bit word of a vertex's adjacency
// row, opcode 1 writes one word of the candidate mask (bits at or above the
// configured vertex count are dropped) and clears the set size, opcode 2 offers
// a vertex, opcode 3 does nothing. Every input word returns exactly one result
// word with the selected flag, the running set size and the echoed vertex.
// Loads, no-ops and offers of vertices that are no longer eligible pass from
// acceptance through execute to the result hand-off; an offer that selects its
// vertex also runs the sweep that clears its sixteen adjacency words from the
// candidate mask, one word per cycle through the single read port of the
// adjacency memory. One item is in flight at a time; the result register lets
// the next item be accepted while a result still waits for m_ready. Adjacency
// words read before being written return arbitrary data. The vertex_count
// register is written over the cfg channel, which is always ready; write it
// only while the engine is idle. It resets to 1024.

module greedy_independent_set_engine_top (
    input  logic                aclk,
    input  logic                aresetn,
    // command words
    input  logic                s_valid,
    output logic                s_ready,
    input  gise_pkg::in_word_t  s_data,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output gise_pkg::out_word_t m_data,
    // vertex_count register
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [gise_pkg::COUNT_W-1:0] cfg_data
);
    import gise_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Configuration writes are captured in the vertex_count register; never stall them.
    assign cfg_ready = 1'b1;

    // Sequence each command: accept, execute, optional mask sweep, hand off result.
    gise_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold adjacency and candidate storage, the set counter and the result register.
    gise_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule
